FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sine/cosine pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk while rst_n is high.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check on the block's own clock and reset.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Formats, constants and inter-stage types of the Taylor sine/cosine core.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int ANGLE_FRAC_BITS = 12;
  localparam int OUT_FRAC_BITS   = 14;

  localparam int ANGLE_W = 16;
  localparam int VALUE_W = 16;
  // reduced angle before folding, holds up to 2pi + pi/2
  localparam int X_W     = 18;
  // expansion argument, magnitude stays below pi/4 + 3pi/4 - pi/2 region bounds
  localparam int A_W     = 14;
  localparam int SQ_W    = 2 * A_W;
  localparam int N_W     = 3 * A_W;

  localparam int SCALE_SH = 2 * ANGLE_FRAC_BITS;
  localparam int CUBIC_SH = 3 * ANGLE_FRAC_BITS - OUT_FRAC_BITS;
  localparam int MID_SH   = 2 * ANGLE_FRAC_BITS + 1 - OUT_FRAC_BITS;

  // floor divide by 6 through a reciprocal multiply
  localparam int U_W         = 18;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = U_W + RECIP_W;

  typedef logic signed [X_W-1:0] xval_t;

  // pi multiples rounded to nearest at ANGLE_FRAC_BITS fraction bits
  localparam xval_t TWO_PI     = 18'sd25736;
  localparam xval_t PI         = 18'sd12868;
  localparam xval_t HALF_PI    = 18'sd6434;
  localparam xval_t QUARTER_PI = 18'sd3217;
  localparam xval_t THREE_Q_PI = 18'sd9651;

  localparam logic signed [N_W-1:0] TWO_S         = N_W'(1) << (SCALE_SH + 1);
  localparam logic signed [N_W-1:0] CUBIC_LIM     = N_W'(6) << (3 * ANGLE_FRAC_BITS);
  localparam logic signed [N_W-1:0] NEG_CUBIC_LIM = -CUBIC_LIM;
  localparam logic signed [N_W-1:0] MID_LIM       = TWO_S;
  localparam logic signed [N_W-1:0] NEG_MID_LIM   = -TWO_S;

  localparam logic [U_W-1:0]     DIV6_BIAS = U_W'(6) << OUT_FRAC_BITS;
  localparam logic [RECIP_W-1:0] RECIP6    = 19'd349526;

  localparam logic signed [VALUE_W-1:0] ONE     = VALUE_W'(1) << OUT_FRAC_BITS;
  localparam logic signed [VALUE_W-1:0] NEG_ONE = -ONE;

  typedef enum logic {
    CMD_SINE   = 1'b0,
    CMD_COSINE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ORIGIN  = 2'd0,
    REG_HALF_PI = 2'd1,
    REG_PI      = 2'd2
  } region_e;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    region_e               region;
    logic                  neg;
  } red_t;

  typedef struct packed {
    logic signed [N_W-1:0] n;
    logic                  mid;
  } poly_t;

endpackage

FILE: sv/tsc_in_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if
// Angle channel: valid/ready handshake with angle and function select.
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  cmd_e                      command;

  modport source (output valid, output angle, output command, input ready);
  modport sink (input valid, input angle, input command, output ready);
endinterface

FILE: sv/tsc_out_if.sv
// ----------------------------------------------------------------------------
// tsc_out_if
// Result channel: valid/ready handshake with the Q1.14 value.
// ----------------------------------------------------------------------------
interface tsc_out_if import tsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: sv/tsc_reduce.sv
// ----------------------------------------------------------------------------
// tsc_reduce
// Two pipeline stages of range reduction: wrap and phase shift, then fold
// at pi and pick the expansion point.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_reduce import tsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tsc_in_if.sink in_i,
  output logic vld_o,
  input  logic rdy_i,
  output red_t red_o
);

  logic    v1_q, v2_q;
  logic    en1, en2;
  logic    is_cos;
  xval_t   x0, xa, xb, xc, x1_q;
  xval_t   xf, a_full;
  logic    flip;
  region_e region;
  red_t    red_d, red_q;

  assign en2        = !v2_q || rdy_i;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;
  assign vld_o      = v2_q;
  assign red_o      = red_q;

  // stage 1: bring negative angles up, shift cosine by pi/2
  assign is_cos = (in_i.command == CMD_COSINE);
  assign x0     = xval_t'(in_i.angle);
  assign xa     = x0[X_W-1] ? x0 + TWO_PI : x0;
  assign xb     = is_cos ? xa + HALF_PI : xa;
  assign xc     = (is_cos && (xb >= TWO_PI)) ? xb - TWO_PI : xb;

  // stage 2: fold the upper half turn, choose the expansion point
  always_comb begin
    flip = (x1_q > PI);
    xf   = flip ? x1_q - PI : x1_q;
    priority if (xf <= QUARTER_PI) begin
      region = REG_ORIGIN;
      a_full = xf;
    end else if (xf <= THREE_Q_PI) begin
      region = REG_HALF_PI;
      a_full = xf - HALF_PI;
    end else begin
      region = REG_PI;
      a_full = xf - PI;
    end
    red_d.a      = a_full[A_W-1:0];
    red_d.region = region;
    red_d.neg    = flip ^ (region == REG_PI);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= xc;
    end
    if (en2) begin
      red_q <= red_d;
    end
  end

  `ASSERT_CLK(red_mid_range, v2_q && (red_q.region == REG_HALF_PI) |-> (red_q.a > QUARTER_PI - HALF_PI) && (red_q.a <= THREE_Q_PI - HALF_PI), "reduced argument outside the pi/2 window")
  `ASSERT_CLK(red_hold, v2_q && !rdy_i |=> v2_q && $stable(red_q), "stalled reduction stage changed")

endmodule

FILE: sv/tsc_poly.sv
// ----------------------------------------------------------------------------
// tsc_poly
// Three pipeline stages of polynomial work: square, cube, then combine
// with the linear or constant term and apply the sign.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_poly import tsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  output logic  rdy_o,
  input  red_t  red_i,
  output logic  vld_o,
  input  logic  rdy_i,
  output poly_t poly_o
);

  logic                   v3_q, v4_q, v5_q;
  logic                   en3, en4, en5;
  logic signed [SQ_W-1:0] sq_d, sq3_q, sq4_q;
  logic signed [A_W-1:0]  a3_q, a4_q;
  region_e                region3_q, region4_q;
  logic                   neg3_q, neg4_q;
  logic signed [N_W-1:0]  cube_d, cube4_q;
  logic signed [N_W-1:0]  a_ext, six_as, lhs, rhs;
  logic                   mid;
  poly_t                  poly_d, poly_q;

  assign en5    = !v5_q || rdy_i;
  assign en4    = !v4_q || en5;
  assign en3    = !v3_q || en4;
  assign rdy_o  = en3;
  assign vld_o  = v5_q;
  assign poly_o = poly_q;

  // stage 3: square
  assign sq_d = SQ_W'(red_i.a) * SQ_W'(red_i.a);

  // stage 4: cube
  assign cube_d = N_W'(sq3_q) * N_W'(a3_q);

  // stage 5: 6*a*2^(2F) by shift and add, then one subtract picks the sign
  always_comb begin
    a_ext  = N_W'(a4_q);
    six_as = (a_ext <<< (SCALE_SH + 2)) + (a_ext <<< (SCALE_SH + 1));
    mid    = (region4_q == REG_HALF_PI);
    lhs    = mid ? TWO_S : six_as;
    rhs    = mid ? N_W'(sq4_q) : cube4_q;
    poly_d.n   = neg4_q ? rhs - lhs : lhs - rhs;
    poly_d.mid = mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= vld_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sq3_q     <= sq_d;
      a3_q      <= red_i.a;
      region3_q <= red_i.region;
      neg3_q    <= red_i.neg;
    end
    if (en4) begin
      sq4_q     <= sq3_q;
      cube4_q   <= cube_d;
      a4_q      <= a3_q;
      region4_q <= region3_q;
      neg4_q    <= neg3_q;
    end
    if (en5) begin
      poly_q <= poly_d;
    end
  end

  `ASSERT_CLK(poly_sq_pos, v4_q |-> !sq4_q[SQ_W-1], "square went negative")

endmodule

FILE: sv/tsc_finish.sv
// ----------------------------------------------------------------------------
// tsc_finish
// Two pipeline stages: saturation test and scaling, then the floor divide
// by six and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsc_finish import tsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  output logic  rdy_o,
  input  poly_t poly_i,
  tsc_out_if.source out_o
);

  logic                      v6_q, v7_q;
  logic                      en6, en7;
  logic signed [N_W-1:0]     n, sh_c, sh_m;
  logic                      sat_hi_d, sat_lo_d;
  logic                      sat_hi_q, sat_lo_q, mid6_q;
  logic [U_W-1:0]            u_d, u6_q;
  logic signed [VALUE_W-1:0] qm_d, qm6_q;
  logic [PROD_W-1:0]         prod;
  logic signed [VALUE_W-1:0] qc, value_d, value_q;

  assign en7         = !v7_q || out_o.ready;
  assign en6         = !v6_q || en7;
  assign rdy_o       = en6;
  assign out_o.valid = v7_q;
  assign out_o.value = value_q;

  // stage 6: clamp test against +-1.0 and floor the power-of-two part
  always_comb begin
    n    = poly_i.n;
    sh_c = n >>> CUBIC_SH;
    sh_m = n >>> MID_SH;
    if (poly_i.mid) begin
      sat_hi_d = (n >= MID_LIM);
      sat_lo_d = (n < NEG_MID_LIM);
    end else begin
      sat_hi_d = (n >= CUBIC_LIM);
      sat_lo_d = (n < NEG_CUBIC_LIM);
    end
    // bias makes the dividend non-negative and a whole multiple of six apart
    u_d  = sh_c[U_W-1:0] + DIV6_BIAS;
    qm_d = sh_m[VALUE_W-1:0];
  end

  // stage 7: floor(u / 6) by reciprocal, remove the bias
  assign prod = PROD_W'(u6_q) * PROD_W'(RECIP6);
  assign qc   = $signed(prod[RECIP_SHIFT +: VALUE_W]) - ONE;

  always_comb begin
    priority if (sat_hi_q) begin
      value_d = ONE;
    end else if (sat_lo_q) begin
      value_d = NEG_ONE;
    end else if (mid6_q) begin
      value_d = qm6_q;
    end else begin
      value_d = qc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en6) begin
        v6_q <= vld_i;
      end
      if (en7) begin
        v7_q <= v6_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      sat_hi_q <= sat_hi_d;
      sat_lo_q <= sat_lo_d;
      mid6_q   <= poly_i.mid;
      u6_q     <= u_d;
      qm6_q    <= qm_d;
    end
    if (en7) begin
      value_q <= value_d;
    end
  end

  `ASSERT_CLK(fin_sat_excl, v6_q |-> !(sat_hi_q && sat_lo_q), "both clamp flags set")
  `ASSERT_CLK(fin_out_range, v7_q |-> (value_q <= ONE) && (value_q >= NEG_ONE), "result beyond plus or minus one")

endmodule

FILE: sv/taylor_sine_cosine_core.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine_core
// Fixed-point sine/cosine by short Taylor expansions around 0, pi/2, pi.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one transaction carries a signed Q3.12 angle in radians and a
//           command (CMD_SINE or CMD_COSINE).
//   out_o : one transaction per input, in order, carrying the Q1.14 result
//           clamped to +-1.0.
//   Seven register stages: reduce (2), square / cube / combine (3),
//   clamp-and-scale (1), divide-by-six and output register (1).
//   Throughput is one transaction per cycle while out_o is not stalled; the
//   two multiplies and the reciprocal divide each sit in a stage of their own.
//   Every stage has its own valid bit and loads when it is empty or when the
//   stage after it loads, so a receiver stall holds the result on out_o,
//   bubbles are squeezed out and in_i keeps accepting until the pipe is full.
//   Reset clears all valid bits; the pipe is empty and ready right after.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_core import tsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tsc_in_if.sink    in_i,
  tsc_out_if.source out_o
);

  // reduction -> polynomial
  logic  red_vld, red_rdy;
  red_t  red;

  // polynomial -> finish
  logic  poly_vld, poly_rdy;
  poly_t poly;

  // Fold the angle into [0, pi] and reduce it around one of three points.
  tsc_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .vld_o  (red_vld),
    .rdy_i  (red_rdy),
    .red_o  (red)
  );

  // Evaluate the chosen expansion exactly, sign included.
  tsc_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (red_vld),
    .rdy_o  (red_rdy),
    .red_i  (red),
    .vld_o  (poly_vld),
    .rdy_i  (poly_rdy),
    .poly_o (poly)
  );

  // Floor to Q1.14, clamp, and drive the output register.
  tsc_finish u_finish (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (poly_vld),
    .rdy_o  (poly_rdy),
    .poly_i (poly),
    .out_o  (out_o)
  );

endmodule

FILE: tb/sv/taylor_sine_cosine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_core_test
// Self-checking bench for the Taylor sine/cosine core. A queue of angle
// transactions feeds a clocked driver, and each accepted angle is turned into
// an expected Q1.14 value by a 64-bit integer model of the range reduction and
// the three expansions. A clocked monitor checks every result in order. Both
// channels idle and stall in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_core_test;
  import tsc_pkg::*;

  // Pi multiples at 12 fraction bits, rounded to nearest.
  localparam longint TWO_PI_Q     = 25736;
  localparam longint PI_Q         = 12868;
  localparam longint HALF_PI_Q    = 6434;
  localparam longint QUARTER_PI_Q = 3217;
  localparam longint THREE_Q_PI_Q = 9651;
  localparam int     ANGLE_FB     = 12;
  localparam int     VALUE_FB     = 14;
  localparam longint SCALE2       = longint'(1) << (2 * ANGLE_FB);
  localparam longint UNITY        = longint'(1) << VALUE_FB;

  localparam int RANDOM_ITEMS = 1426;
  // no idling on either side once this few transactions are left
  localparam int CALM_TAIL    = 150;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    cmd_e                      command;
  } angle_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tsc_in_if  in_if ();
  tsc_out_if out_if ();

  taylor_sine_cosine_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  angle_item_t               pending_q[$];
  logic signed [VALUE_W-1:0] value_exp_q[$];
  angle_item_t               next_item;
  int                        total_items;
  int                        accepted;
  int                        received;
  int                        errors;
  int                        gap_left;
  int                        stall_left;
  int                        drive_idle_pct;
  int                        stall_pct;
  int                        cycles;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Floor n / (m * 2^(12k)) to 14 fraction bits and clamp to +-1.0.
  function automatic longint floor_q14(longint n, longint m, int k);
    int     sc;
    longint den;
    longint q;
    sc  = k * ANGLE_FB;
    den = m * (longint'(1) << sc);
    if (n >= den) return UNITY;
    if (n < -den) return -UNITY;
    q = n / m;
    if ((n % m) != 0 && n < 0) q = q - 1;
    // the shift is at least 10 here, so an arithmetic shift floors
    q = q >>> (sc - VALUE_FB);
    if (q > UNITY) q = UNITY;
    if (q < -UNITY) q = -UNITY;
    return q;
  endfunction

  function automatic logic signed [VALUE_W-1:0] taylor_value(
      logic signed [ANGLE_W-1:0] angle, cmd_e command);
    longint x;
    longint a;
    longint n;
    longint r;
    bit     flip;
    x    = angle;
    flip = 1'b0;
    // bring a negative angle into 0..2pi, then shift cosine onto sine
    if (x < 0) x += TWO_PI_Q;
    if (command == CMD_COSINE) begin
      x += HALF_PI_Q;
      if (x >= TWO_PI_Q) x -= TWO_PI_Q;
    end
    // fold the upper half-turn and flip the sign of the result
    if (x > PI_Q) begin
      x -= PI_Q;
      flip = 1'b1;
    end
    if (x <= QUARTER_PI_Q) begin
      n = 6 * x * SCALE2 - x * x * x;
      if (flip) n = -n;
      r = floor_q14(n, 6, 3);
    end else if (x <= THREE_Q_PI_Q) begin
      a = x - HALF_PI_Q;
      n = 2 * SCALE2 - a * a;
      if (flip) n = -n;
      r = floor_q14(n, 2, 2);
    end else begin
      a = x - PI_Q;
      n = a * a * a - 6 * a * SCALE2;
      if (flip) n = -n;
      r = floor_q14(n, 6, 3);
    end
    return r[VALUE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pop pending angles onto in_if, predict on every accepted
  // transaction, and insert random idle bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.angle   <= '0;
      in_if.command <= CMD_SINE;
      gap_left       = 0;
      drive_idle_pct = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        value_exp_q.push_back(taylor_value(in_if.angle, in_if.command));
        accepted++;
        // change the idling density every hundred transactions
        if (accepted % 100 == 0) begin
          case ($urandom_range(2))
            0: drive_idle_pct = 0;
            1: drive_idle_pct = 10;
            default: drive_idle_pct = 35;
          endcase
        end
      end
      // hold the payload while the core stalls the channel
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          if (pending_q.size() > CALM_TAIL && $urandom_range(99) < drive_idle_pct) begin
            // idle this cycle and draw a random idle gap into gap_left
            gap_left = $urandom_range(4);
            in_if.valid <= 1'b0;
          end else begin
            next_item = pending_q.pop_front();
            in_if.valid   <= 1'b1;
            in_if.angle   <= next_item.angle;
            in_if.command <= next_item.command;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation and drop
  // ready in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left    = 0;
      stall_pct     = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        received++;
        if (value_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected value: expected none, actual %0d",
                   $time, out_if.value);
        end else begin
          if (out_if.value !== value_exp_q[0]) begin
            errors++;
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, value_exp_q[0], out_if.value);
          end
          void'(value_exp_q.pop_front());
        end
        if (received % 100 == 0) begin
          case ($urandom_range(2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 35;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (total_items - received > CALM_TAIL &&
                   $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** taylor_sine_cosine_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    logic signed [ANGLE_W-1:0] marks[8];
    int                        pick;
    marks = '{16'sd0, 16'sd3217, 16'sd9651, 16'sd12868,
              16'sd19302, 16'sd25736, -16'sd3217, -16'sd12868};
    pick = $urandom_range(99);
    if (pick < 80) begin
      // the specified range, -2pi..2pi
      return ANGLE_W'(int'($urandom_range(51472)) - 25736);
    end else if (pick < 90) begin
      // close to a region boundary or the cosine wrap point
      return marks[$urandom_range(7)] + ANGLE_W'(int'($urandom_range(8)) - 4);
    end else begin
      // anywhere in the field, outside -2pi..2pi included
      return ANGLE_W'($urandom());
    end
  endfunction

  initial begin
    logic signed [ANGLE_W-1:0] corner_angles[12];
    angle_item_t               item;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.angle   = '0;
    in_if.command = CMD_SINE;
    out_if.ready  = 1'b0;
    accepted      = 0;
    received      = 0;
    errors        = 0;
    cycles        = 0;

    // Directed: zero, the region edges at pi/4, 3pi/4 and pi, pi itself, the
    // cosine wrap at 2pi, both ends of the range and both ends of the field.
    corner_angles = '{16'sd0, -16'sd1, 16'sd3217, 16'sd9651, 16'sd9652,
                      16'sd12868, 16'sd12869, 16'sd19302, 16'sd25736,
                      -16'sd25736, 16'sd32767, -16'sd32768};
    foreach (corner_angles[i]) begin
      item.angle   = corner_angles[i];
      item.command = CMD_SINE;
      pending_q.push_back(item);
      item.command = CMD_COSINE;
      pending_q.push_back(item);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      item.angle   = random_angle();
      item.command = cmd_e'($urandom_range(1));
      pending_q.push_back(item);
    end
    total_items = pending_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // advance until every angle is taken and every result is back
    while (pending_q.size() != 0 || in_if.valid || value_exp_q.size() != 0)
      @(negedge clk_i);
    // leave room for any stray result past the pipeline depth
    repeat (20) @(negedge clk_i);

    if (errors == 0) begin
      $display("** taylor_sine_cosine_core: PASSED **");
    end else begin
      $display("** taylor_sine_cosine_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tsc_pkg.sv
sv/tsc_in_if.sv
sv/tsc_out_if.sv
sv/tsc_reduce.sv
sv/tsc_poly.sv
sv/tsc_finish.sv
sv/taylor_sine_cosine_core.sv
tb/sv/taylor_sine_cosine_core_test.sv
